@@ sv/lfopm_pkg.sv @@
`default_nettype none
package lfopm_pkg;

    // datapath sizing
    localparam int INDEX_BITS         = 32;
    localparam int PHASE_BITS         = 16;
    localparam int SINE_TABLE_ENTRIES = 256;

    // field and register widths
    localparam int STEP_W    = 32;
    localparam int PERCENT_W = 9;
    localparam int WAVE_W    = 2;
    localparam int CYCLE_W   = 16;
    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 2'd2;

    // wave selector codes
    localparam logic [WAVE_W-1:0] WAVE_NONE     = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

    // long division of {index, PHASE_BITS zeros}: one quotient bit a stage
    localparam int DIV_STAGES = INDEX_BITS + PHASE_BITS;

    localparam int SINE_W     = 15;
    localparam int J_W        = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int POS_W      = PHASE_BITS - 1;
    localparam int JPROD_W    = POS_W + J_W;
    localparam int WAVE_VAL_W = 17;
    localparam int TRI_SUM_W  = 19;
    localparam int PROD_W     = WAVE_VAL_W + DEPTH_W + 1;
    localparam int MSUM_W     = PROD_W + 1;
    localparam int M_W        = 32;
    localparam int PCT_PROD_W = M_W + 7;
    localparam int Q29_FRAC   = 29;

    localparam logic [POS_W-1:0]   QUARTER_TURN  = POS_W'(1) << (PHASE_BITS - 2);
    localparam logic [MSUM_W-1:0]  ONE_Q29       = MSUM_W'(1) << Q29_FRAC;
    localparam logic [PCT_PROD_W-1:0] PCT_SCALE  = PCT_PROD_W'(100);
    localparam logic [PERCENT_W-1:0]  PERCENT_UNITY = PERCENT_W'(100);
    localparam logic [PERCENT_W-1:0]  PERCENT_MAX   = PERCENT_W'(499);
    localparam logic [J_W-1:0]     J_LAST        = J_W'(SINE_TABLE_ENTRIES);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

    // x^2 times the previous term, all in Q2.30
    function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // quarter-wave sine in Q0.15, evaluated at elaboration
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t         tab;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
            term = x;
            sum  = $signed(x);
            term = taylor_next(term, x) / 6;
            sum  = sum - $signed(term);
            term = taylor_next(term, x) / 20;
            sum  = sum + $signed(term);
            term = taylor_next(term, x) / 42;
            sum  = sum - $signed(term);
            term = taylor_next(term, x) / 72;
            sum  = sum + $signed(term);
            term = taylor_next(term, x) / 110;
            sum  = sum - $signed(term);
            term = taylor_next(term, x) / 156;
            sum  = sum + $signed(term);
            term = taylor_next(term, x) / 210;
            sum  = sum - $signed(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            v = ($unsigned(sum) + 64'd16384) >> 15;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            tab[i] = SINE_W'(v);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

@@ sv/lfo_percent_modulator_core.sv @@
`default_nettype none
// lfo velocity multiplier
// request in: in_valid / in_stall with step_index; one percent result per request,
// returned in request order on out_valid / out_stall.
// configuration: cfg_we writes cfg_data into register cfg_index (0 wave type,
// 1 cycle length, 2 depth); other indexes are ignored. write only while idle.
// pipeline: 53 register stages from the accepting edge to out_valid (48 divider
// stages, four wave and scaling stages, one output register).
// throughput: one request per cycle while no waiting result is stalled; each
// divider stage is one compare-subtract that retires one quotient bit of the phase.
// reset clears the config registers and valid flags (wave type none, so results read 100) and empties
// the pipeline; no output is valid until a request has gone through.
// a stall while a result is waiting holds the whole pipeline and raises in_stall
// in the same cycle; nothing is dropped or repeated, and a request can still be
// taken in any cycle in which the waiting result is being taken.
module lfo_percent_modulator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lfopm_pkg::STEP_W-1:0]      step_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lfopm_pkg::PERCENT_W-1:0]   percent,
    input  logic                              cfg_we,
    input  logic [lfopm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfopm_pkg::CFG_W-1:0]       cfg_data
);
    import lfopm_pkg::*;

    logic en;

    logic [WAVE_W-1:0]  wave_type_reg;
    logic [CYCLE_W-1:0] period_len_reg;
    logic [DEPTH_W-1:0] mod_depth_reg;

    // divider stages
    logic [DIV_STAGES-1:0] div_vld_reg;
    logic [CYCLE_W-1:0]    rem_reg  [DIV_STAGES];
    logic [CYCLE_W-1:0]    rem_next [DIV_STAGES];
    logic [INDEX_BITS-1:0] sh_reg   [DIV_STAGES];
    logic [INDEX_BITS-1:0] sh_next  [DIV_STAGES];
    logic [PHASE_BITS-1:0] q_reg    [DIV_STAGES];
    logic [PHASE_BITS-1:0] q_next   [DIV_STAGES];

    // wave and scaling stages
    logic                         w1_vld_reg;
    logic [J_W-1:0]               j_reg, j_next;
    logic                         neg_reg, neg_next;
    logic signed [WAVE_VAL_W-1:0] tri_reg, tri_next;
    logic                         w2_vld_reg;
    logic signed [WAVE_VAL_W-1:0] wave_reg, wave_next;
    logic                         w3_vld_reg;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic                         w4_vld_reg;
    logic [M_W-1:0]               m_reg, m_next;
    logic                         out_vld_reg;
    logic [PERCENT_W-1:0]         percent_reg, percent_next;

    logic [PHASE_BITS-1:0] phase;

    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_vld_reg;
    assign percent   = percent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg  <= WAVE_NONE;
            period_len_reg <= '0;
            mod_depth_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVE_TYPE: wave_type_reg  <= WAVE_W'(cfg_data);
                REG_PERIOD:    period_len_reg <= CYCLE_W'(cfg_data);
                REG_MOD_DEPTH: mod_depth_reg  <= DEPTH_W'(cfg_data);
                default:       ;
            endcase
        end
    end

    // restoring division: remainder stays below a nonzero period, quotient bits
    // after the index bits form the phase fraction
    always_comb
    begin
        logic [CYCLE_W-1:0]    src_rem;
        logic [INDEX_BITS-1:0] src_sh;
        logic [PHASE_BITS-1:0] src_q;
        logic [CYCLE_W:0]      t;
        logic [CYCLE_W:0]      diff;
        logic                  ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                src_rem = '0;
                src_sh  = INDEX_BITS'(step_index);
                src_q   = '0;
            end
            else
            begin
                src_rem = rem_reg[s-1];
                src_sh  = sh_reg[s-1];
                src_q   = q_reg[s-1];
            end
            t    = {src_rem, src_sh[INDEX_BITS-1]};
            diff = t - {1'b0, period_len_reg};
            ge   = (t >= {1'b0, period_len_reg});
            rem_next[s] = ge ? diff[CYCLE_W-1:0] : t[CYCLE_W-1:0];
            sh_next[s]  = src_sh << 1;
            q_next[s]   = {src_q[PHASE_BITS-2:0], ge};
        end
    end

    assign phase = q_reg[DIV_STAGES-1];

    // quadrant decode, table index and triangle
    always_comb
    begin
        logic [1:0]                  quad;
        logic [POS_W-1:0]            pos;
        logic [JPROD_W-1:0]          jprod;
        logic [JPROD_W-1:0]          jfull;
        logic [WAVE_VAL_W-1:0]       v;
        logic signed [TRI_SUM_W-1:0] vs;
        logic signed [TRI_SUM_W-1:0] tri_sum;
        quad = phase[PHASE_BITS-1 -: 2];
        pos  = {1'b0, phase[PHASE_BITS-3:0]};
        if (quad[0])
        begin
            pos = QUARTER_TURN - pos;
        end
        jprod = JPROD_W'(pos) * JPROD_W'(SINE_TABLE_ENTRIES);
        jfull = jprod >> (PHASE_BITS - 2);
        if (jfull > JPROD_W'(SINE_TABLE_ENTRIES))
        begin
            j_next = J_LAST;
        end
        else
        begin
            j_next = jfull[J_W-1:0];
        end
        neg_next = quad[1];

        v  = WAVE_VAL_W'({phase, 17'b0} >> PHASE_BITS);
        vs = $signed(TRI_SUM_W'(v));
        case (quad)
            2'b00:       tri_sum = vs;
            2'b01, 2'b10: tri_sum = TRI_SUM_W'(65536) - vs;
            default:     tri_sum = vs - TRI_SUM_W'(131072);
        endcase
        tri_next = WAVE_VAL_W'(tri_sum);
    end

    // table read and wave select
    always_comb
    begin
        logic signed [WAVE_VAL_W-1:0] sine_mag;
        sine_mag = $signed({2'b00, SINE_TAB[j_reg]});
        case (wave_type_reg)
            WAVE_SINE:     wave_next = neg_reg ? -sine_mag : sine_mag;
            WAVE_TRIANGLE: wave_next = tri_reg;
            default:       wave_next = '0;
        endcase
    end

    assign prod_next = PROD_W'(wave_reg) * $signed({1'b0, mod_depth_reg});

    always_comb
    begin
        logic signed [MSUM_W-1:0] msum;
        msum = MSUM_W'(prod_reg) + $signed(ONE_Q29);
        m_next = msum[MSUM_W-1] ? '0 : M_W'(msum);
    end

    always_comb
    begin
        logic [PCT_PROD_W-1:0] scaled;
        scaled = (PCT_PROD_W'(m_reg) * PCT_SCALE) >> Q29_FRAC;
        if (wave_type_reg == WAVE_NONE || period_len_reg == '0)
        begin
            percent_next = PERCENT_UNITY;
        end
        else
        begin
            percent_next = scaled[PERCENT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            w1_vld_reg  <= 1'b0;
            w2_vld_reg  <= 1'b0;
            w3_vld_reg  <= 1'b0;
            w4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg <= {div_vld_reg[DIV_STAGES-2:0], in_valid};
            w1_vld_reg  <= div_vld_reg[DIV_STAGES-1];
            w2_vld_reg  <= w1_vld_reg;
            w3_vld_reg  <= w2_vld_reg;
            w4_vld_reg  <= w3_vld_reg;
            out_vld_reg <= w4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                sh_reg[s]  <= sh_next[s];
                q_reg[s]   <= q_next[s];
            end
            j_reg       <= j_next;
            neg_reg     <= neg_next;
            tri_reg     <= tri_next;
            wave_reg    <= wave_next;
            prod_reg    <= prod_next;
            m_reg       <= m_next;
            percent_reg <= percent_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/lfopm_checker.sv @@
`default_nettype none
module lfopm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [lfopm_pkg::PERCENT_W-1:0] percent
);
    import lfopm_pkg::*;

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(percent))
        else $error("result changed while stalled");

    // the multiplier never exceeds five times unity
    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> percent <= PERCENT_MAX)
        else $error("percent out of range");

    // requests are only held off by a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a stalled result");

endmodule

bind lfo_percent_modulator_core lfopm_checker u_lfopm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .percent   (percent)
);
`default_nettype wire
